[design/nnfd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package nnfd_pkg;

    // field widths
    localparam int DimW     = 13;
    localparam int FnW      = 32;
    localparam int TsW      = 63;
    localparam int PixW     = 32;
    localparam int ProdW    = 2 * DimW;
    localparam int InDataW  = 160;
    localparam int OutDataW = 160;
    localparam int CfgIdxW  = 1;

    // input tdata layout
    localparam int InSwLo  = 0;
    localparam int InShLo  = InSwLo + DimW;
    localparam int InFnLo  = InShLo + DimW;
    localparam int InTsLo  = InFnLo + FnW;
    localparam int InPixLo = InTsLo + TsW;

    // output tdata layout
    localparam int OutOkBit = 0;
    localparam int OutDwLo  = 1;
    localparam int OutDhLo  = OutDwLo + DimW;
    localparam int OutFnLo  = OutDhLo + DimW;
    localparam int OutTsLo  = OutFnLo + FnW;
    localparam int OutPixLo = OutTsLo + TsW;
    localparam int OutUsedW = OutPixLo + PixW;

    // item codes
    localparam logic OpHeader   = 1'b0;
    localparam logic OpPixel    = 1'b1;
    localparam logic KindHeader = 1'b0;
    localparam logic KindPixel  = 1'b1;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] CfgBoxWidth  = 1'd0;
    localparam logic [CfgIdxW-1:0] CfgBoxHeight = 1'd1;

    localparam logic [DimW-1:0] BoxWidthReset  = 13'd640;
    localparam logic [DimW-1:0] BoxHeightReset = 13'd480;

    // shared multiplier operand selection
    localparam logic [1:0] MulBhDen = 2'd0;
    localparam logic [1:0] MulNumSh = 2'd1;
    localparam logic [1:0] MulSwNum = 2'd2;
    localparam logic [1:0] MulShNum = 2'd3;

    // divider job selection
    localparam logic [1:0] DivDstW  = 2'd0;
    localparam logic [1:0] DivDstH  = 2'd1;
    localparam logic [1:0] DivStepC = 2'd2;
    localparam logic [1:0] DivStepR = 2'd3;

    typedef struct packed {
        logic       hdr_latch;
        logic       pix_accept;
        logic [1:0] mul_sel;
        logic       cmp_first;
        logic       cmp_second;
        logic       div_start;
        logic [1:0] div_sel;
        logic       div_store;
        logic       emit_hdr;
    } t_dp_cmd;

    typedef struct packed {
        logic hdr_ok;
        logic div_done;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

[design/nnfd_div.sv]
`timescale 1ns / 1ps
`default_nettype none

module nnfd_div (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [nnfd_pkg::ProdW-1:0]   i_dividend,
    input  wire logic [nnfd_pkg::DimW-1:0]    i_divisor,
    output logic                              o_done,
    output logic [nnfd_pkg::ProdW-1:0]        o_quotient,
    output logic [nnfd_pkg::DimW-1:0]         o_remainder
);

    localparam int CntW = $clog2(nnfd_pkg::ProdW + 1);
    localparam logic [CntW-1:0] Steps = CntW'(nnfd_pkg::ProdW);

    logic [CntW-1:0]              r_cnt, n_cnt;
    logic                         r_done, n_done;
    logic [nnfd_pkg::ProdW-1:0]   r_quo, n_quo;
    logic [nnfd_pkg::DimW-1:0]    r_rem, n_rem;
    logic [nnfd_pkg::DimW-1:0]    r_dvs, n_dvs;
    logic [nnfd_pkg::DimW:0]      trial;

    // one quotient bit per cycle, restoring
    always_comb begin
        n_cnt  = r_cnt;
        n_done = 1'b0;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        trial  = {r_rem, r_quo[nnfd_pkg::ProdW-1]};
        if (i_start) begin
            n_cnt = Steps;
            n_quo = i_dividend;
            n_rem = '0;
            n_dvs = i_divisor;
        end else if (r_cnt != '0) begin
            n_cnt = r_cnt - CntW'(1);
            n_done = (r_cnt == CntW'(1));
            if (trial >= {1'b0, r_dvs}) begin
                n_rem = nnfd_pkg::DimW'(trial - {1'b0, r_dvs});
                n_quo = {r_quo[nnfd_pkg::ProdW-2:0], 1'b1};
            end else begin
                n_rem = trial[nnfd_pkg::DimW-1:0];
                n_quo = {r_quo[nnfd_pkg::ProdW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

`default_nettype wire

[design/nnfd_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none

module nnfd_datapath (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire nnfd_pkg::t_dp_cmd                 i_cmd,
    output nnfd_pkg::t_dp_status                   o_status,
    input  wire logic                              i_cfg_we,
    input  wire logic [nnfd_pkg::CfgIdxW-1:0]      i_cfg_idx,
    input  wire logic [nnfd_pkg::DimW-1:0]         i_cfg_data,
    input  wire logic [nnfd_pkg::InDataW-1:0]      i_in_data,
    input  wire logic                              i_out_ready,
    output logic                                   o_out_valid,
    output logic [nnfd_pkg::OutDataW-1:0]          o_out_data,
    output logic [1:0]                             o_out_user,
    output logic                                   o_out_last
);

    localparam int W  = nnfd_pkg::DimW;
    localparam int PW = nnfd_pkg::ProdW;

    // configuration
    logic [W-1:0] r_box_w, r_box_h;

    // header working registers
    logic                   r_ok;
    logic [nnfd_pkg::FnW-1:0] r_fn;
    logic [nnfd_pkg::TsW-1:0] r_ts;
    logic [W-1:0]           r_num, r_den;
    logic [PW-1:0]          r_prod;

    // frame state
    logic         r_active, n_active;
    logic [W-1:0] r_sw, r_sh, r_dw, r_dh;
    logic [W-1:0] r_sx, n_sx, r_sy, n_sy;
    logic [W-1:0] r_px, n_px, r_py, n_py;
    logic [W-1:0] r_cq, n_cq, r_cr, n_cr;
    logic [W-1:0] r_rq, n_rq, r_rr, n_rr;
    logic [W-1:0] r_scq, r_scr, r_srq, r_srr;

    // output register
    logic                            r_out_valid;
    logic [nnfd_pkg::OutDataW-1:0]   r_out_data;
    logic [1:0]                      r_out_user;
    logic                            r_out_last;

    logic [W-1:0]  in_sw, in_sh;
    logic [W-1:0]  mul_a, mul_b;
    logic [PW-1:0] mul_p;
    logic [PW-1:0] div_dividend;
    logic [W-1:0]  div_divisor;
    logic          div_done;
    logic [PW-1:0] div_quo;
    logic [W-1:0]  div_rem;
    logic [W-1:0]  div_q13;

    logic          row_hit, pix_hit, line_end, frame_end, out_free, pix_load;
    logic [W:0]    px_inc, py_inc, sx_inc, sy_inc, cr_sum, rr_sum;

    assign in_sw = i_in_data[nnfd_pkg::InSwLo +: W];
    assign in_sh = i_in_data[nnfd_pkg::InShLo +: W];

    // one shared 13x13 multiplier
    always_comb begin
        case (i_cmd.mul_sel)
            nnfd_pkg::MulBhDen: begin mul_a = r_box_h; mul_b = r_den; end
            nnfd_pkg::MulNumSh: begin mul_a = r_num;   mul_b = r_sh;  end
            nnfd_pkg::MulSwNum: begin mul_a = r_sw;    mul_b = r_num; end
            nnfd_pkg::MulShNum: begin mul_a = r_sh;    mul_b = r_num; end
            default:            begin mul_a = r_sw;    mul_b = r_num; end
        endcase
    end
    assign mul_p = PW'(mul_a) * PW'(mul_b);

    always_comb begin
        case (i_cmd.div_sel)
            nnfd_pkg::DivDstW:  begin div_dividend = mul_p;      div_divisor = r_den; end
            nnfd_pkg::DivDstH:  begin div_dividend = mul_p;      div_divisor = r_den; end
            nnfd_pkg::DivStepC: begin div_dividend = PW'(r_sw);  div_divisor = r_dw;  end
            nnfd_pkg::DivStepR: begin div_dividend = PW'(r_sh);  div_divisor = r_dh;  end
            default:            begin div_dividend = mul_p;      div_divisor = r_den; end
        endcase
    end

    nnfd_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    // preview sizes and steps never exceed the source size
    assign div_q13 = div_quo[W-1:0];

    // pixel selection
    assign row_hit   = (r_sy == r_rq);
    assign pix_hit   = row_hit && (r_sx == r_cq) && (r_px < r_dw) && (r_py < r_dh);
    assign px_inc    = {1'b0, r_px} + (W+1)'(1);
    assign py_inc    = {1'b0, r_py} + (W+1)'(1);
    assign sx_inc    = {1'b0, r_sx} + (W+1)'(1);
    assign sy_inc    = {1'b0, r_sy} + (W+1)'(1);
    assign cr_sum    = {1'b0, r_cr} + {1'b0, r_scr};
    assign rr_sum    = {1'b0, r_rr} + {1'b0, r_srr};
    assign line_end  = (px_inc == {1'b0, r_dw});
    assign frame_end = line_end && (py_inc == {1'b0, r_dh});
    assign out_free  = !r_out_valid || i_out_ready;
    assign pix_load  = i_cmd.pix_accept && r_active && pix_hit;

    always_comb begin
        n_active = r_active;
        n_sx = r_sx;
        n_sy = r_sy;
        n_px = r_px;
        n_py = r_py;
        n_cq = r_cq;
        n_cr = r_cr;
        n_rq = r_rq;
        n_rr = r_rr;
        if (i_cmd.hdr_latch) begin
            // the frame in progress is abandoned
            n_active = 1'b0;
        end else if (i_cmd.emit_hdr) begin
            n_active = r_ok;
            n_sx = '0;
            n_sy = '0;
            n_px = '0;
            n_py = '0;
            n_cq = '0;
            n_cr = '0;
            n_rq = '0;
            n_rr = '0;
        end else if (i_cmd.pix_accept && r_active) begin
            if (pix_hit) begin
                n_px = px_inc[W-1:0];
                if (cr_sum >= {1'b0, r_dw}) begin
                    n_cr = W'(cr_sum - {1'b0, r_dw});
                    n_cq = r_cq + r_scq + W'(1);
                end else begin
                    n_cr = cr_sum[W-1:0];
                    n_cq = r_cq + r_scq;
                end
            end
            n_sx = sx_inc[W-1:0];
            if (sx_inc >= {1'b0, r_sw}) begin
                n_sx = '0;
                if (row_hit) begin
                    n_py = py_inc[W-1:0];
                    n_px = '0;
                    n_cq = '0;
                    n_cr = '0;
                    if (rr_sum >= {1'b0, r_dh}) begin
                        n_rr = W'(rr_sum - {1'b0, r_dh});
                        n_rq = r_rq + r_srq + W'(1);
                    end else begin
                        n_rr = rr_sum[W-1:0];
                        n_rq = r_rq + r_srq;
                    end
                end
                n_sy = sy_inc[W-1:0];
                if (sy_inc >= {1'b0, r_sh}) begin
                    n_active = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_w     <= nnfd_pkg::BoxWidthReset;
            r_box_h     <= nnfd_pkg::BoxHeightReset;
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    nnfd_pkg::CfgBoxWidth:  r_box_w <= i_cfg_data;
                    nnfd_pkg::CfgBoxHeight: r_box_h <= i_cfg_data;
                    default: ;
                endcase
            end
            r_active <= n_active;
            if (i_cmd.emit_hdr || pix_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end

        r_sx <= n_sx;
        r_sy <= n_sy;
        r_px <= n_px;
        r_py <= n_py;
        r_cq <= n_cq;
        r_cr <= n_cr;
        r_rq <= n_rq;
        r_rr <= n_rr;

        if (i_cmd.hdr_latch) begin
            r_sw <= in_sw;
            r_sh <= in_sh;
            r_fn <= i_in_data[nnfd_pkg::InFnLo +: nnfd_pkg::FnW];
            r_ts <= i_in_data[nnfd_pkg::InTsLo +: nnfd_pkg::TsW];
            r_ok <= (in_sw != '0) && (in_sh != '0) && (r_box_w != '0) && (r_box_h != '0);
            // width limit: scale is box_width / src_width or one
            if (r_box_w < in_sw) begin
                r_num <= r_box_w;
                r_den <= in_sw;
            end else begin
                r_num <= W'(1);
                r_den <= W'(1);
            end
        end
        if (i_cmd.cmp_first) begin
            r_prod <= mul_p;
        end
        // height limit: cross-multiplied compare box_height/src_height < num/den
        if (i_cmd.cmp_second && (r_prod < mul_p)) begin
            r_num <= r_box_h;
            r_den <= r_sh;
        end
        if (i_cmd.div_store && div_done) begin
            case (i_cmd.div_sel)
                nnfd_pkg::DivDstW:  r_dw <= (div_q13 == '0) ? W'(1) : div_q13;
                nnfd_pkg::DivDstH:  r_dh <= (div_q13 == '0) ? W'(1) : div_q13;
                nnfd_pkg::DivStepC: begin r_scq <= div_q13; r_scr <= div_rem; end
                nnfd_pkg::DivStepR: begin r_srq <= div_q13; r_srr <= div_rem; end
                default: ;
            endcase
        end

        if (i_cmd.emit_hdr) begin
            // pixel field and pad are zero in a header
            r_out_data <= {{(nnfd_pkg::OutDataW - nnfd_pkg::OutPixLo){1'b0}},
                           r_ts, r_fn,
                           r_ok ? r_dh : W'(0),
                           r_ok ? r_dw : W'(0),
                           r_ok};
            r_out_user <= {1'b0, nnfd_pkg::KindHeader};
            r_out_last <= 1'b0;
        end else if (pix_load) begin
            r_out_data <= {{(nnfd_pkg::OutDataW - nnfd_pkg::OutUsedW){1'b0}},
                           i_in_data[nnfd_pkg::InPixLo +: nnfd_pkg::PixW],
                           {nnfd_pkg::OutPixLo{1'b0}}};
            r_out_user <= {line_end, nnfd_pkg::KindPixel};
            r_out_last <= frame_end;
        end
    end

    always_comb begin
        o_status.hdr_ok   = r_ok;
        o_status.div_done = div_done;
        o_status.out_free = out_free;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_user  = r_out_user;
    assign o_out_last  = r_out_last;

endmodule

`default_nettype wire

[design/nnfd_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module nnfd_ctrl (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    input  wire logic                  i_in_op,
    output logic                       o_in_ready,
    input  wire nnfd_pkg::t_dp_status  i_status,
    output nnfd_pkg::t_dp_cmd          o_cmd
);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_CMP0    = 4'd1;
    localparam logic [3:0] ST_CMP1    = 4'd2;
    localparam logic [3:0] ST_DW_GO   = 4'd3;
    localparam logic [3:0] ST_DW_WAIT = 4'd4;
    localparam logic [3:0] ST_DH_GO   = 4'd5;
    localparam logic [3:0] ST_DH_WAIT = 4'd6;
    localparam logic [3:0] ST_SC_GO   = 4'd7;
    localparam logic [3:0] ST_SC_WAIT = 4'd8;
    localparam logic [3:0] ST_SR_GO   = 4'd9;
    localparam logic [3:0] ST_SR_WAIT = 4'd10;
    localparam logic [3:0] ST_DONE    = 4'd11;

    logic [3:0] r_state, n_state;
    logic       accept;

    assign o_in_ready = (r_state == ST_IDLE) && i_status.out_free;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state          = r_state;
        o_cmd            = '0;
        o_cmd.mul_sel    = nnfd_pkg::MulSwNum;
        o_cmd.div_sel    = nnfd_pkg::DivDstW;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_in_op == nnfd_pkg::OpHeader) begin
                        o_cmd.hdr_latch = 1'b1;
                        n_state = ST_CMP0;
                    end else begin
                        o_cmd.pix_accept = 1'b1;
                    end
                end
            end
            ST_CMP0: begin
                o_cmd.mul_sel   = nnfd_pkg::MulBhDen;
                o_cmd.cmp_first = 1'b1;
                n_state = i_status.hdr_ok ? ST_CMP1 : ST_DONE;
            end
            ST_CMP1: begin
                o_cmd.mul_sel    = nnfd_pkg::MulNumSh;
                o_cmd.cmp_second = 1'b1;
                n_state = ST_DW_GO;
            end
            ST_DW_GO: begin
                o_cmd.mul_sel   = nnfd_pkg::MulSwNum;
                o_cmd.div_sel   = nnfd_pkg::DivDstW;
                o_cmd.div_start = 1'b1;
                n_state = ST_DW_WAIT;
            end
            ST_DW_WAIT: begin
                o_cmd.div_sel   = nnfd_pkg::DivDstW;
                o_cmd.div_store = 1'b1;
                if (i_status.div_done) n_state = ST_DH_GO;
            end
            ST_DH_GO: begin
                o_cmd.mul_sel   = nnfd_pkg::MulShNum;
                o_cmd.div_sel   = nnfd_pkg::DivDstH;
                o_cmd.div_start = 1'b1;
                n_state = ST_DH_WAIT;
            end
            ST_DH_WAIT: begin
                o_cmd.div_sel   = nnfd_pkg::DivDstH;
                o_cmd.div_store = 1'b1;
                if (i_status.div_done) n_state = ST_SC_GO;
            end
            ST_SC_GO: begin
                o_cmd.div_sel   = nnfd_pkg::DivStepC;
                o_cmd.div_start = 1'b1;
                n_state = ST_SC_WAIT;
            end
            ST_SC_WAIT: begin
                o_cmd.div_sel   = nnfd_pkg::DivStepC;
                o_cmd.div_store = 1'b1;
                if (i_status.div_done) n_state = ST_SR_GO;
            end
            ST_SR_GO: begin
                o_cmd.div_sel   = nnfd_pkg::DivStepR;
                o_cmd.div_start = 1'b1;
                n_state = ST_SR_WAIT;
            end
            ST_SR_WAIT: begin
                o_cmd.div_sel   = nnfd_pkg::DivStepR;
                o_cmd.div_store = 1'b1;
                if (i_status.div_done) n_state = ST_DONE;
            end
            ST_DONE: begin
                // header result waits for room in the output register
                if (i_status.out_free) begin
                    o_cmd.emit_hdr = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

[design/nearest_neighbor_fit_downscaler.sv]
// Nearest-neighbor preview downscaler.
// Slave stream s_axis carries frame headers (tuser = 0) and raster-order
// source pixels (tuser = 1). For each header the block fits the source size
// into the box_width x box_height box, keeping aspect and never upscaling,
// and sends one preview header on m_axis (tuser[0] = 0). Pixels that land on
// the nearest-neighbor grid go out as preview pixels (tuser[0] = 1) with
// tuser[1] marking the end of a preview row and tlast the end of the frame;
// all others are dropped without a result.
// Pixels: one request per cycle while idle and the output is free; result in the cycle after acceptance.
// Headers: two compare steps, four passes of the shared radix-2 divider
// (start, 26 steps, done; two preview sizes, two per-pixel step ratios)
// and the load of the output; an invalid header goes from the first
// compare straight to the load. s_axis_tready is low meanwhile.
// A single output register parts the two sides: a new pixel is taken in the
// same cycle that the waiting result is taken. When the receiver stalls,
// the result holds and s_axis_tready drops until it is taken.
// Reset: no frame active, output empty, box set to 640 x 480.
// Configuration writes are taken at once and are meant for idle periods.
`timescale 1ns / 1ps
`default_nettype none

module nearest_neighbor_fit_downscaler (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [nnfd_pkg::CfgIdxW-1:0]     i_cfg_idx,
    input  wire logic [nnfd_pkg::DimW-1:0]        i_cfg_data,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // src_width, src_height, frame_number, time_stamp, pixel_word, zero pad
    input  wire logic [nnfd_pkg::InDataW-1:0]     s_axis_tdata,
    // op
    input  wire logic                             s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // frame_ok, dst_width, dst_height, out_frame_number, out_time_stamp,
    // out_pixel, zero pad
    output logic [nnfd_pkg::OutDataW-1:0]         m_axis_tdata,
    // kind, line_end
    output logic [1:0]                            m_axis_tuser,
    // frame_end
    output logic                                  m_axis_tlast
);

    nnfd_pkg::t_dp_cmd    cmd;
    nnfd_pkg::t_dp_status status;

    nnfd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_op    (s_axis_tuser),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    nnfd_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (s_axis_tdata),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_user  (m_axis_tuser),
        .o_out_last  (m_axis_tlast)
    );

endmodule

`default_nettype wire
